// ----- hdl/rme_pkg.sv -----
// Package for the rotation matrix to Euler angle unit: widths, CORDIC angle table,
// scaling constants and the per-stage CORDIC record. No dependencies.
`timescale 1ns / 1ps

package rme_pkg;

    // entries carry this many fraction bits; sy and the threshold share the scale
    localparam int ELEMENT_FRACTION_BITS = 14;
    localparam int ELEM_W       = 16;
    localparam int GUARD_BITS   = 16;
    localparam int VEC_W        = 40;
    localparam int ANG_W        = 34;
    localparam int ATAN_LEN     = 32;
    localparam int THR_W        = 15;
    localparam int OUT_W        = 16;
    localparam int ANGLE_LIMIT  = 25736;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [30:0] PI_Q29       = 31'd1686629713;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
    } cordic_t;

    function automatic ang_t atan_units(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return ang_t'({2'b00, v});
    endfunction

    // quadrant pre-rotation into the right half plane
    function automatic cordic_t cordic_init(input vec_t x, input vec_t y);
        cordic_t c;
        c.x = x;
        c.y = y;
        c.z = '0;
        if (x < 0) begin
            c.x = -x;
            c.y = -y;
            c.z = (y >= 0) ? ang_t'(34'sd2147483648) : ang_t'(-34'sd2147483648);
        end
        return c;
    endfunction

    function automatic cordic_t cordic_iter(input cordic_t c, input logic [4:0] i);
        cordic_t n;
        vec_t dx;
        vec_t dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (c.y >= 0) begin
            n.x = c.x + dx;
            n.y = c.y - dy;
            n.z = c.z + atan_units(i);
        end else begin
            n.x = c.x - dx;
            n.y = c.y + dy;
            n.z = c.z - atan_units(i);
        end
        return n;
    endfunction

    function automatic vec_t widen(input logic signed [ELEM_W-1:0] e);
        return vec_t'({{(VEC_W-ELEM_W-GUARD_BITS){e[ELEM_W-1]}}, e, {GUARD_BITS{1'b0}}});
    endfunction

endpackage

// ----- hdl/rme_cordic.sv -----
// Pipelined vectoring CORDIC, one registered iteration per stage, with a side
// payload carried in step. Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_cordic
    import rme_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  vec_t              in_x,
    input  vec_t              in_y,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output vec_t              out_mag,
    output ang_t              out_ang,
    output logic [SIDE_W-1:0] out_side
);

    localparam int RUN = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;

    cordic_t           st_reg   [RUN+1];
    logic [SIDE_W-1:0] side_reg [RUN+1];
    logic [RUN:0]      vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[RUN-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]   <= cordic_init(in_x, in_y);
            side_reg[0] <= in_side;
        end
    end

    for (genvar g = 0; g < RUN; g++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g+1]   <= cordic_iter(st_reg[g], 5'(g));
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    // zero vector stays zero through every stage except z; x==y==0 gives z of
    // accumulated table, so zero it where the vector was zero at entry
    logic [RUN:0] zero_reg;
    always_ff @(posedge clk)
    begin
        if (en) zero_reg <= {zero_reg[RUN-1:0], (in_x == '0) && (in_y == '0)};
    end

    assign out_valid = vld_reg[RUN];
    assign out_mag   = zero_reg[RUN] ? vec_t'(0) : st_reg[RUN].x;
    assign out_ang   = zero_reg[RUN] ? ang_t'(0) : st_reg[RUN].z;
    assign out_side  = side_reg[RUN];

endmodule

// ----- hdl/rme_angle_out.sv -----
// Turn units to Q2.13 radians: registered multiply by pi, then round and clamp.
// Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_angle_out
    import rme_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  ang_t                    ang,
    output logic signed [OUT_W-1:0] q213
);

    logic signed [65:0] prod_reg;
    logic signed [65:0] rnd;
    logic signed [18:0] sh;

    always_ff @(posedge clk)
    begin
        if (en) prod_reg <= 66'(ang) * $signed({1'b0, PI_Q29});
    end

    always_comb
    begin
        rnd = prod_reg + (66'sd1 <<< 46);
        sh  = 19'(rnd >>> 47);
        if (sh > 19'sd25736)       q213 = OUT_W'(ANGLE_LIMIT);
        else if (sh < -19'sd25736) q213 = -OUT_W'(ANGLE_LIMIT);
        else                       q213 = sh[OUT_W-1:0];
    end

endmodule

// ----- hdl/rotation_matrix_to_euler_unit.sv -----
// Top level of the rotation matrix to Euler angle unit (x-y-z order).
// Depends on rme_pkg, rme_cordic and rme_angle_out.
`timescale 1ns / 1ps

// Fully pipelined: one item per cycle while out_stall does not hold a result; the
// path registers through two CORDICs (each an entry register plus one register per
// iteration), the gain multiply, the angle multiply and the output register.
// A first CORDIC forms sy and yaw from (r00, r10); after a gain multiply and the
// threshold compare, a second pair of CORDICs gives pitch and roll. A stall
// freezes the whole pipeline; a one-entry output register feeds the result.
module rotation_matrix_to_euler_unit
    import rme_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [THR_W-1:0]        cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [ELEM_W-1:0] r00,
    input  logic signed [ELEM_W-1:0] r10,
    input  logic signed [ELEM_W-1:0] r11,
    input  logic signed [ELEM_W-1:0] r12,
    input  logic signed [ELEM_W-1:0] r20,
    input  logic signed [ELEM_W-1:0] r21,
    input  logic signed [ELEM_W-1:0] r22,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] roll_angle,
    output logic signed [OUT_W-1:0] pitch_angle,
    output logic signed [OUT_W-1:0] yaw_angle,
    output logic                    singular_flag
);

    localparam int SIDE1_W = 5 * VEC_W;
    localparam int SIDE2_W = ANG_W + 1;

    logic [THR_W-1:0] thr_reg;
    logic             en;
    logic             ovld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)      thr_reg <= THR_W'(1);
        else if (cfg_we) thr_reg <= cfg_wdata;
    end

    // pipeline advances unless a held result is being stalled
    assign en       = !(ovld_reg && out_stall);
    assign in_stall = !en;

    // stage A: sy/yaw
    logic              a_vld;
    vec_t              a_mag;
    ang_t              a_ang;
    logic [SIDE1_W-1:0] a_side;

    rme_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE1_W)) u_cordic_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .in_x(widen(r00)), .in_y(widen(r10)),
        .in_side({widen(r11), widen(r12), widen(r20), widen(r21), widen(r22)}),
        .out_valid(a_vld), .out_mag(a_mag), .out_ang(a_ang), .out_side(a_side)
    );

    // gain multiply, registered
    logic               m_vld_reg;
    logic signed [70:0] m_prod_reg;
    ang_t               m_ang_reg;
    logic [SIDE1_W-1:0] m_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  m_vld_reg <= 1'b0;
        else if (en) m_vld_reg <= a_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_prod_reg <= 71'(a_mag) * $signed({1'b0, INV_GAIN_Q30});
            m_ang_reg  <= a_ang;
            m_side_reg <= a_side;
        end
    end

    vec_t m_sy;
    logic m_sing;
    vec_t s_r11, s_r12, s_r20, s_r21, s_r22;
    assign m_sy   = VEC_W'(m_prod_reg >>> 30);
    assign m_sing = m_sy < $signed({1'b0, thr_reg, {GUARD_BITS{1'b0}}});
    assign {s_r11, s_r12, s_r20, s_r21, s_r22} = m_side_reg;

    // stage B: pitch and roll in parallel
    logic b_vld, b_vld2;
    vec_t b_mag_p, b_mag_r;
    ang_t b_pitch, b_roll;
    logic [SIDE2_W-1:0] b_side, b_side2;

    rme_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE2_W)) u_cordic_p (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_vld_reg),
        .in_x(m_sy), .in_y(-s_r20),
        .in_side({m_sing, m_sing ? ang_t'(0) : m_ang_reg}),
        .out_valid(b_vld), .out_mag(b_mag_p), .out_ang(b_pitch), .out_side(b_side)
    );

    rme_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE2_W)) u_cordic_r (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(m_vld_reg),
        .in_x(m_sing ? s_r11 : s_r22), .in_y(m_sing ? -s_r12 : s_r21),
        .in_side({m_sing, ang_t'(0)}),
        .out_valid(b_vld2), .out_mag(b_mag_r), .out_ang(b_roll), .out_side(b_side2)
    );

    // conversion: multiply stage inside rme_angle_out, then output register
    logic c_vld_reg, c_sing_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  c_vld_reg <= 1'b0;
        else if (en) c_vld_reg <= b_vld;
    end
    always_ff @(posedge clk)
    begin
        if (en) c_sing_reg <= b_side[SIDE2_W-1];
    end

    logic signed [OUT_W-1:0] roll_q, pitch_q, yaw_q;
    rme_angle_out u_out_r (.clk(clk), .en(en), .ang(b_roll),  .q213(roll_q));
    rme_angle_out u_out_p (.clk(clk), .en(en), .ang(b_pitch), .q213(pitch_q));
    rme_angle_out u_out_y (.clk(clk), .en(en), .ang(b_side[ANG_W-1:0]), .q213(yaw_q));

    logic signed [OUT_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                    sing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)  ovld_reg <= 1'b0;
        else if (en) ovld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_q;
            pitch_reg <= pitch_q;
            yaw_reg   <= yaw_q;
            sing_reg  <= c_sing_reg;
        end
    end

    assign out_valid     = ovld_reg;
    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign yaw_angle     = yaw_reg;
    assign singular_flag = sing_reg;

`ifndef NO_ASSERTIONS
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld == b_vld2) else $error("pitch and roll lanes out of step");
    a_side_match: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld |-> b_side[SIDE2_W-1] == b_side2[SIDE2_W-1])
        else $error("singular flag differs between lanes");
    a_sing_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        (ovld_reg && sing_reg) |-> yaw_reg == '0) else $error("yaw not zero when singular");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ovld_reg && out_stall) |-> $stable(roll_reg) && ovld_reg)
        else $error("stalled result changed");
`endif

endmodule
